### rtl/apd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apd_pkg;

    // Frame status codes, in priority order
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_SYNC  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_CHECKSUM  = 3'd4,
        ST_NO_CODE   = 3'd5
    } status_t;

    // Result kind codes
    localparam logic KIND_PARAM   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Register word index on the configuration port
    localparam logic REG_SYNC_WORD = 1'b0;

    // Frame layout positions
    localparam logic [16:0] POS_HDR_A  = 17'd2;
    localparam logic [16:0] POS_HDR_B  = 17'd4;
    localparam logic [16:0] POS_LEN    = 17'd6;
    localparam logic [16:0] POS_CODE   = 17'd8;
    localparam logic [16:0] POS_PARAM  = 17'd10;
    localparam logic [16:0] POS_MAX    = 17'h1FFFF;
    localparam logic [16:0] MIN_FRAME  = 17'd12;

    // One queued result
    typedef struct packed {
        logic        kind;
        logic [7:0]  param_byte;
        logic [10:0] apid;
        logic [1:0]  seg_flags;
        logic [13:0] seq_count;
        logic [15:0] command_code;
        logic [15:0] param_count;
        status_t     status;
        logic        run_end;
    } result_t;

endpackage

`default_nettype wire

### rtl/ack_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// A result is written into the registered result queue when its byte is taken.
// Throughput: one byte per cycle while in_stall is low; a byte that closes the buffer
// inside the parameter field yields two results, a parameter result and a summary.
// A four-entry result queue decouples the sides; input stalls when under two free.
// Reset (rst_n low, asynchronous) clears frame state, the queue and the sync word.
module ack_packet_deframer
    import apd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        buffer_end,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       param_byte,
    output logic [10:0]      apid,
    output logic [1:0]       seg_flags,
    output logic [13:0]      seq_count,
    output logic [15:0]      command_code,
    output logic [15:0]      param_count,
    output logic [2:0]       status,
    output logic             run_end,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration register
    logic [15:0] sync_word_reg;

    // Frame state
    logic [16:0] pos_reg,     pos_next;
    logic [15:0] sum_reg,     sum_next;
    logic [15:0] sync_reg,    sync_next;
    logic [15:0] hdr_a_reg,   hdr_a_next;
    logic [15:0] hdr_b_reg,   hdr_b_next;
    logic [15:0] len_reg,     len_next;
    logic [15:0] code_reg,    code_next;
    logic [15:0] trail_reg,   trail_next;

    // Result queue
    result_t     queue_reg [4];
    logic [1:0]  wr_ptr_reg,  wr_ptr_next;
    logic [1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [2:0]  count_reg,   count_next;

    logic        in_take;
    logic        out_take;
    logic [16:0] lim_data;
    logic [16:0] lim_trail;
    logic [16:0] frame_need;
    logic [16:0] pos_inc;
    logic [15:0] upd_sum;
    logic [15:0] upd_sync;
    logic [15:0] upd_hdr_a;
    logic [15:0] upd_hdr_b;
    logic [15:0] upd_len;
    logic [15:0] upd_code;
    logic [15:0] upd_trail;
    logic        emit_param;
    logic        emit_summary;
    status_t     frame_status;
    result_t     param_item;
    result_t     summary_item;
    logic [1:0]  summary_slot;
    logic [2:0]  push_count;
    logic        cfg_write;

    assign in_take  = in_valid & ~in_stall;
    assign out_take = out_valid & ~out_stall;

    // Stall input unless two queue slots are free
    assign in_stall  = (count_reg > 3'd2);
    assign out_valid = (count_reg != 3'd0);

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_SYNC_WORD)
        begin
            prdata = {16'd0, sync_word_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= 16'd0;
        end
        else if (cfg_write && (paddr[2] == REG_SYNC_WORD))
        begin
            sync_word_reg <= pwdata[15:0];
        end
    end

    // Bounds derived from the length field seen so far
    assign lim_data  = {1'b0, len_reg} + 17'd8;
    assign lim_trail = {1'b0, len_reg} + 17'd9;

    // Parse one byte and update the frame fields
    always_comb
    begin
        upd_sync  = sync_reg;
        upd_hdr_a = hdr_a_reg;
        upd_hdr_b = hdr_b_reg;
        upd_len   = len_reg;
        upd_code  = code_reg;
        upd_sum   = sum_reg;
        upd_trail = trail_reg;

        if (pos_reg < POS_HDR_A)
        begin
            upd_sync = {sync_reg[7:0], rx_byte};
        end
        else if (pos_reg < POS_HDR_B)
        begin
            upd_hdr_a = {hdr_a_reg[7:0], rx_byte};
        end
        else if (pos_reg < POS_LEN)
        begin
            upd_hdr_b = {hdr_b_reg[7:0], rx_byte};
        end
        else if (pos_reg < POS_CODE)
        begin
            upd_len = {len_reg[7:0], rx_byte};
        end

        if ((pos_reg == POS_CODE) || (pos_reg == POS_CODE + 17'd1))
        begin
            upd_code = {code_reg[7:0], rx_byte};
        end

        if ((pos_reg >= POS_HDR_A) && ((pos_reg < POS_CODE) || (pos_reg <= lim_data)))
        begin
            upd_sum = sum_reg + {8'd0, rx_byte};
        end

        if ((pos_reg >= POS_CODE) &&
            ((pos_reg == lim_trail) || (pos_reg == lim_trail + 17'd1)))
        begin
            upd_trail = {trail_reg[7:0], rx_byte};
        end
    end

    assign emit_param   = (pos_reg >= POS_PARAM) && (pos_reg <= lim_data);
    assign emit_summary = buffer_end;
    assign pos_inc      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 17'd1;
    assign frame_need   = {1'b0, upd_len} + 17'd11;

    // Check the closed frame in priority order
    always_comb
    begin
        if (pos_inc < MIN_FRAME)
        begin
            frame_status = ST_SHORT;
        end
        else if (upd_sync != sync_word_reg)
        begin
            frame_status = ST_BAD_SYNC;
        end
        else if (pos_inc < frame_need)
        begin
            frame_status = ST_TRUNCATED;
        end
        else if (upd_trail != ~upd_sum)
        begin
            frame_status = ST_CHECKSUM;
        end
        else if (upd_len == 16'd0)
        begin
            frame_status = ST_NO_CODE;
        end
        else
        begin
            frame_status = ST_OK;
        end
    end

    // Build result items
    always_comb
    begin
        param_item            = '0;
        param_item.kind       = KIND_PARAM;
        param_item.param_byte = rx_byte;
        param_item.status     = ST_OK;

        summary_item         = '0;
        summary_item.kind    = KIND_SUMMARY;
        summary_item.status  = frame_status;
        summary_item.run_end = 1'b1;
        if (frame_status == ST_OK)
        begin
            summary_item.apid         = upd_hdr_a[10:0];
            summary_item.seg_flags    = upd_hdr_b[15:14];
            summary_item.seq_count    = upd_hdr_b[13:0];
            summary_item.command_code = upd_code;
            summary_item.param_count  = upd_len - 16'd1;
        end
    end

    // Frame state next values: advance on a byte, clear at buffer end
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        sync_next  = sync_reg;
        hdr_a_next = hdr_a_reg;
        hdr_b_next = hdr_b_reg;
        len_next   = len_reg;
        code_next  = code_reg;
        trail_next = trail_reg;
        if (in_take)
        begin
            if (buffer_end)
            begin
                pos_next   = '0;
                sum_next   = '0;
                sync_next  = '0;
                hdr_a_next = '0;
                hdr_b_next = '0;
                len_next   = '0;
                code_next  = '0;
                trail_next = '0;
            end
            else
            begin
                pos_next   = pos_inc;
                sum_next   = upd_sum;
                sync_next  = upd_sync;
                hdr_a_next = upd_hdr_a;
                hdr_b_next = upd_hdr_b;
                len_next   = upd_len;
                code_next  = upd_code;
                trail_next = upd_trail;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            sync_reg  <= '0;
            hdr_a_reg <= '0;
            hdr_b_reg <= '0;
            len_reg   <= '0;
            code_reg  <= '0;
            trail_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            sync_reg  <= sync_next;
            hdr_a_reg <= hdr_a_next;
            hdr_b_reg <= hdr_b_next;
            len_reg   <= len_next;
            code_reg  <= code_next;
            trail_reg <= trail_next;
        end
    end

    // Queue pointers and fill count
    assign summary_slot = wr_ptr_reg + {1'b0, emit_param};
    assign push_count   = in_take ? ({2'b00, emit_param} + {2'b00, emit_summary}) : 3'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, out_take};
        count_next  = count_reg + push_count - {2'b00, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write up to two requests into the queue
    always_ff @(posedge clk)
    begin
        if (in_take && emit_param)
        begin
            queue_reg[wr_ptr_reg] <= param_item;
        end
        if (in_take && emit_summary)
        begin
            queue_reg[summary_slot] <= summary_item;
        end
    end

    // Drive the head request
    always_comb
    begin
        kind         = queue_reg[rd_ptr_reg].kind;
        param_byte   = queue_reg[rd_ptr_reg].param_byte;
        apid         = queue_reg[rd_ptr_reg].apid;
        seg_flags    = queue_reg[rd_ptr_reg].seg_flags;
        seq_count    = queue_reg[rd_ptr_reg].seq_count;
        command_code = queue_reg[rd_ptr_reg].command_code;
        param_count  = queue_reg[rd_ptr_reg].param_count;
        status       = queue_reg[rd_ptr_reg].status;
        run_end      = queue_reg[rd_ptr_reg].run_end;
    end

endmodule

`default_nettype wire
